### rtl/rdc_pkg.sv
// rdc_pkg: shared constants, types and helper functions for the radix digit converter
// no dependencies; used by rdc_ctrl, rdc_dp, radix_digit_converter_top and rdc_checker
`default_nettype none

package rdc_pkg;

  // field and datapath widths
  localparam int INPUT_BITS = 16;
  localparam int VALUE_W    = 16;
  localparam int RADIX_W    = 4;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int PACKED_W   = 50;
  // packed accumulator: up to nineteen decimal places of value at most 8
  localparam int ACC_W      = 64;
  localparam int MAX_DIGITS = INPUT_BITS;

  // reciprocal division: floor(n / d) == (n * ceil(2^k / d)) >> k for n below 2^(k-4)
  localparam int QUO_SHIFT = INPUT_BITS + 4;
  localparam int RECIP_W   = QUO_SHIFT;
  localparam int PROD_W    = INPUT_BITS + RECIP_W;
  localparam int REM_W     = INPUT_BITS + RADIX_W;

  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd1) / 64'd2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd2) / 64'd3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd3) / 64'd4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd4) / 64'd5);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd5) / 64'd6);
  localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd6) / 64'd7);
  localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd7) / 64'd8);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((64'd1 << QUO_SHIFT) + 64'd8) / 64'd9);

  // packed result saturates at all ones
  localparam logic [ACC_W-1:0] PACKED_MAX = ACC_W'((65'd1 << PACKED_W) - 65'd1);

  // radix register
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(9);

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_RADIX = '0;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // take a new value, clear count and accumulator
    logic advance;   // next quotient into the rest register
    logic push;      // store one digit from the previous rest and quotient
    logic horner;    // fold the top digit into the packed accumulator
    logic out_load;  // move the finished result into the output register
  } rdc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rest_zero;    // quotient just produced is zero
    logic horner_last;  // one packing step remains
  } rdc_status_t;

  // clamp the register value into the supported radix range
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // reciprocal of the radix for the quotient multiply
  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] base);
    logic [RECIP_W-1:0] res;
    unique case (base)
      4'd3:    res = RECIP_3;
      4'd4:    res = RECIP_4;
      4'd5:    res = RECIP_5;
      4'd6:    res = RECIP_6;
      4'd7:    res = RECIP_7;
      4'd8:    res = RECIP_8;
      4'd9:    res = RECIP_9;
      default: res = RECIP_2;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/rdc_ctrl.sv
// rdc_ctrl: sequencing state machine for the radix digit converter
// depends on rdc_pkg for the command and status structs
`default_nettype none

module rdc_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  rdc_pkg::rdc_status_t  status,
  output rdc_pkg::rdc_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_STEP,
    S_HORNER,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.advance = 1'b1;
        state_next  = S_STEP;
      end
      S_STEP: begin
        cmd.push    = 1'b1;
        cmd.advance = 1'b1;
        if (status.rest_zero) state_next = S_HORNER;
      end
      S_HORNER: begin
        cmd.horner = 1'b1;
        if (status.horner_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rdc_dp.sv
// rdc_dp: datapath for the radix digit converter
// quotient multiply, digit shift line, decimal packing accumulator, output register; uses rdc_pkg
`default_nettype none

module rdc_dp (
  input  wire                                   clk,
  input  wire  [rdc_pkg::VALUE_W-1:0]           value_in,
  input  wire  [rdc_pkg::RADIX_W-1:0]           radix,
  input  rdc_pkg::rdc_cmd_t                     cmd,
  output rdc_pkg::rdc_status_t                  status,
  output logic [rdc_pkg::PACKED_W-1:0]          digits_as_decimal,
  output logic [rdc_pkg::COUNT_W-1:0]           digit_count
);

  logic [rdc_pkg::INPUT_BITS-1:0] rest;
  logic [rdc_pkg::INPUT_BITS-1:0] prev;
  logic [rdc_pkg::RADIX_W-1:0]    base;
  logic [rdc_pkg::COUNT_W-1:0]    count;
  logic [rdc_pkg::COUNT_W-1:0]    hleft;
  logic [rdc_pkg::ACC_W-1:0]      acc;
  logic [rdc_pkg::DIGIT_W-1:0]    dig [rdc_pkg::MAX_DIGITS];

  logic [rdc_pkg::PROD_W-1:0]     quo_prod;
  logic [rdc_pkg::INPUT_BITS-1:0] quo;
  logic [rdc_pkg::REM_W-1:0]      back_prod;
  logic [rdc_pkg::REM_W-1:0]      rem_full;
  logic [rdc_pkg::DIGIT_W-1:0]    digit;
  logic [rdc_pkg::ACC_W-1:0]      acc_next;
  logic [rdc_pkg::ACC_W-1:0]      acc_sat;

  // quotient of the current rest by reciprocal multiply
  assign quo_prod = rdc_pkg::PROD_W'(rest) * rdc_pkg::PROD_W'(rdc_pkg::recip(base));
  assign quo      = quo_prod[rdc_pkg::PROD_W-1:rdc_pkg::QUO_SHIFT];

  // digit is the previous rest minus the registered quotient times the radix
  assign back_prod = rdc_pkg::REM_W'(rest) * rdc_pkg::REM_W'(base);
  assign rem_full  = rdc_pkg::REM_W'(prev) - back_prod;
  assign digit     = rem_full[rdc_pkg::DIGIT_W-1:0];

  // times ten plus the most significant remaining digit
  assign acc_next = (acc << 3) + (acc << 1) + rdc_pkg::ACC_W'(dig[0]);
  assign acc_sat  = (acc > rdc_pkg::PACKED_MAX) ? rdc_pkg::PACKED_MAX : acc;

  assign status.rest_zero   = (rest == '0);
  assign status.horner_last = (hleft == rdc_pkg::COUNT_W'(1));

  // rest, quotient pipeline and counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest  <= rdc_pkg::INPUT_BITS'(value_in);
      base  <= rdc_pkg::eff_radix(radix);
      count <= '0;
      acc   <= '0;
    end else begin
      if (cmd.advance) begin
        prev <= rest;
        rest <= quo;
      end
      if (cmd.push) begin
        count <= count + rdc_pkg::COUNT_W'(1);
        hleft <= count + rdc_pkg::COUNT_W'(1);
      end
      if (cmd.horner) begin
        acc   <= acc_next;
        hleft <= hleft - rdc_pkg::COUNT_W'(1);
      end
    end
  end

  // digit shift line: least significant digit enters first, most significant leaves first
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      dig[0] <= digit;
      for (int i = 1; i < rdc_pkg::MAX_DIGITS; i++) begin
        dig[i] <= dig[i-1];
      end
    end else if (cmd.horner) begin
      for (int i = 0; i < rdc_pkg::MAX_DIGITS - 1; i++) begin
        dig[i] <= dig[i+1];
      end
      dig[rdc_pkg::MAX_DIGITS-1] <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digits_as_decimal <= acc_sat[rdc_pkg::PACKED_W-1:0];
      digit_count       <= count;
    end
  end

endmodule

`default_nettype wire

### rtl/radix_digit_converter_top.sv
// radix_digit_converter_top: top level with the apb radix register, controller and datapath
// depends on rdc_pkg, rdc_ctrl and rdc_dp
`default_nettype none

// Converts an unsigned value to its digits in radix 2 to 9 (register 0, reset 2; values below
// 2 act as 2, above 9 as 9) and returns them packed as a decimal-looking number with the digit
// count, zero giving 0 with one digit. One item is worked on at a time: for a result of n digits
// an item takes n quotient steps through the reciprocal multiplier and then n times-ten packing
// steps through the 64-bit accumulator. The result sits in an output register, so the next item
// is taken while it waits for the consumer. The user must write the radix only while the block
// is idle; the block itself does not enforce this.
module radix_digit_converter_top (
  input  wire                              clk,
  input  wire                              rst,
  // input channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [rdc_pkg::VALUE_W-1:0]      value_in,
  // output channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [rdc_pkg::PACKED_W-1:0]     digits_as_decimal,
  output logic [rdc_pkg::COUNT_W-1:0]      digit_count,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [rdc_pkg::ADDR_W-1:0]       paddr,
  input  wire  [rdc_pkg::DATA_W-1:0]       pwdata,
  output logic [rdc_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  logic [rdc_pkg::RADIX_W-1:0] radix;
  logic                        reg_hit;
  rdc_pkg::rdc_cmd_t           cmd;
  rdc_pkg::rdc_status_t        status;

  // register decode
  assign pready  = 1'b1;
  assign reg_hit = (paddr[rdc_pkg::ADDR_W-1:2] == rdc_pkg::REG_RADIX);
  assign prdata  = reg_hit ? rdc_pkg::DATA_W'(radix) : '0;

  // radix register write on the access phase transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      radix <= pwdata[rdc_pkg::RADIX_W-1:0];
    end
  end

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdc_dp u_dp (
    .clk               (clk),
    .value_in          (value_in),
    .radix             (radix),
    .cmd               (cmd),
    .status            (status),
    .digits_as_decimal (digits_as_decimal),
    .digit_count       (digit_count)
  );

endmodule

`default_nettype wire

### rtl/rdc_checker.sv
// rdc_port_checker: port-level assertions for radix_digit_converter_top, attached by bind
// depends on rdc_pkg for widths and the input size
`default_nettype none

module rdc_port_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [rdc_pkg::PACKED_W-1:0]   digits_as_decimal,
  input wire [rdc_pkg::COUNT_W-1:0]    digit_count
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digits_as_decimal) && $stable(digit_count))
    else $error("result changed while stalled");

  // digit count stays within one and the input width
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_count != '0 &&
                  digit_count <= rdc_pkg::COUNT_W'(rdc_pkg::INPUT_BITS))
    else $error("digit count out of range");

  // a single digit is below nine
  assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_count == rdc_pkg::COUNT_W'(1) |->
      digits_as_decimal <= rdc_pkg::PACKED_W'(8))
    else $error("single digit result too large");

  // busy right after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a conversion runs");

  // no result can appear the cycle after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind radix_digit_converter_top rdc_port_checker u_rdc_port_checker (.*);

`default_nettype wire
